@@ design/tksd_pkg.sv @@
package tksd_pkg;

    localparam int SYM_W   = 14;
    localparam int DIR_W   = 4;
    localparam int BTN_W   = 6;
    localparam int SLOT_W  = 39;
    localparam int STEP_W  = 7;
    localparam int LEN_W   = 3;
    localparam int WIN_W   = 8;
    localparam int ELAP_W  = 9;
    localparam int MASK_W  = 8;
    localparam int IDX_W   = 3;
    localparam int LEN_LSB  = 0;
    localparam int WIN_LSB  = 3;
    localparam int STEP_LSB = 11;

    // symbol codes, also the bit numbers of the folded symbol word
    localparam logic [3:0] SYM_F  = 4'd0;
    localparam logic [3:0] SYM_B  = 4'd1;
    localparam logic [3:0] SYM_D  = 4'd2;
    localparam logic [3:0] SYM_U  = 4'd3;
    localparam logic [3:0] SYM_DF = 4'd4;
    localparam logic [3:0] SYM_DB = 4'd5;
    localparam logic [3:0] SYM_UF = 4'd6;
    localparam logic [3:0] SYM_UB = 4'd7;
    localparam logic [3:0] SYM_LAST = 4'd13;

    localparam logic [1:0] KIND_PRESS   = 2'd0;
    localparam logic [1:0] KIND_HOLD    = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    localparam logic [SYM_W-1:0] GRP_F = 14'b00_0000_0101_0001;
    localparam logic [SYM_W-1:0] GRP_B = 14'b00_0000_1010_0010;
    localparam logic [SYM_W-1:0] GRP_D = 14'b00_0000_0011_0100;
    localparam logic [SYM_W-1:0] GRP_U = 14'b00_0000_1100_1000;

    localparam logic signed [ELAP_W-1:0] ELAP_IDLE = -9'sd1;
    localparam logic signed [ELAP_W-1:0] ELAP_MAX  = 9'sd255;

    function automatic logic [SYM_W-1:0] fold_inputs(
        input logic [DIR_W-1:0] dirs,
        input logic [BTN_W-1:0] btns
    );
        logic f, b, d, u, df, db, uf, ub;
        f  = dirs[0];
        b  = dirs[1];
        d  = dirs[2];
        u  = dirs[3];
        df = 1'b0;
        db = 1'b0;
        uf = 1'b0;
        ub = 1'b0;
        if (d && f)
        begin
            d = 1'b0; f = 1'b0; df = 1'b1;
        end
        if (d && b)
        begin
            d = 1'b0; b = 1'b0; db = 1'b1;
        end
        if (u && f)
        begin
            u = 1'b0; f = 1'b0; uf = 1'b1;
        end
        if (u && b)
        begin
            u = 1'b0; b = 1'b0; ub = 1'b1;
        end
        return {btns, ub, uf, db, df, u, d, b, f};
    endfunction

    function automatic logic step_match(
        input logic [STEP_W-1:0] step,
        input logic [SYM_W-1:0]  last,
        input logic [SYM_W-1:0]  now
    );
        logic [3:0]       sym;
        logic [1:0]       kind;
        logic             four;
        logic [SYM_W-1:0] grp;
        logic             l, n;
        logic             hit;
        sym  = step[3:0];
        kind = step[5:4];
        four = step[6];
        grp  = '0;
        if (sym <= SYM_LAST)
            grp = SYM_W'(1) << sym;
        if (four && kind != KIND_RELEASE)
        begin
            case (sym)
                SYM_F:   grp = GRP_F;
                SYM_B:   grp = GRP_B;
                SYM_D:   grp = GRP_D;
                SYM_U:   grp = GRP_U;
                default: grp = grp;
            endcase
        end
        l = |(last & grp);
        n = |(now & grp);
        case (kind)
            KIND_PRESS:   hit = n && !l;
            KIND_HOLD:    hit = n && l;
            KIND_RELEASE: hit = l && !n;
            default:      hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

@@ design/timed_key_sequence_detector_core.sv @@
// Command sequence detector. Each input beat is one sampling tick of four
// directions and six buttons; the block folds opposite-axis pairs into
// diagonals and steps up to NUM_SLOTS command slots (each up to MAX_STEPS
// steps with a tick window) in parallel, returning one result beat per tick
// with the completed-command mask and the folded symbols. One beat is taken
// every clock cycle unless the master side stalls; a beat's result passes the
// input register and the result register before it is offered on the master
// side, and a result waiting there leaves the input register free for one
// more beat. The user must write slot registers through cfg_we/cfg_index/cfg_data
// only while no beat is in flight (not enforced); an index >= NUM_SLOTS is dropped.
module timed_key_sequence_detector_core #(
    parameter int NUM_SLOTS = 8,
    parameter int MAX_STEPS = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [tksd_pkg::IDX_W-1:0]  cfg_index,
    input  logic [tksd_pkg::SLOT_W-1:0] cfg_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [15:0]                 s_tdata,   // raw_directions[3:0], raw_buttons[9:4]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [23:0]                 m_tdata    // completed_mask[7:0], folded_symbols[21:8]
);
    import tksd_pkg::*;

    localparam int PW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

    logic                    in_valid_reg;
    logic [DIR_W-1:0]        dirs_reg;
    logic [BTN_W-1:0]        btns_reg;
    logic                    out_valid_reg;
    logic [MASK_W-1:0]       mask_reg;
    logic [SYM_W-1:0]        sym_reg;
    logic [SYM_W-1:0]        prev_reg;
    logic [SLOT_W-1:0]       cfg_reg     [NUM_SLOTS];
    logic [PW-1:0]           pos_reg     [NUM_SLOTS];
    logic [PW-1:0]           pos_next    [NUM_SLOTS];
    logic signed [ELAP_W-1:0] elapsed_reg  [NUM_SLOTS];
    logic signed [ELAP_W-1:0] elapsed_next [NUM_SLOTS];
    logic                    prog_reg    [NUM_SLOTS];
    logic                    prog_next   [NUM_SLOTS];
    logic [MASK_W-1:0]       mask_next;
    logic [SYM_W-1:0]        now_sym;
    logic                    advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, sym_reg, mask_reg};
    assign now_sym  = fold_inputs(dirs_reg, btns_reg);

    always_comb
    begin
        logic [LEN_W-1:0]         len;
        logic [WIN_W-1:0]         win;
        logic [PW-1:0]            pos;
        logic [LEN_W-1:0]         pos_inc;
        logic signed [ELAP_W-1:0] elap;
        logic                     prog;
        logic [STEP_W-1:0]        step;
        mask_next = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            pos_inc = '0;
            len = cfg_reg[i][LEN_LSB +: LEN_W];
            if (len > LEN_W'(MAX_STEPS))
                len = LEN_W'(MAX_STEPS);
            win  = cfg_reg[i][WIN_LSB +: WIN_W];
            pos  = pos_reg[i];
            elap = elapsed_reg[i];
            prog = prog_reg[i];
            // window expired: drop progress
            if (elap >= $signed({1'b0, win}))
            begin
                pos  = '0;
                elap = ELAP_IDLE;
                prog = 1'b0;
            end
            if (LEN_W'(pos) >= len)
                pos = '0;
            step = cfg_reg[i][STEP_LSB + STEP_W * int'(pos) +: STEP_W];
            if (len != '0 && step_match(step, prev_reg, now_sym))
            begin
                if (pos == '0)
                    prog = 1'b1;
                pos_inc = LEN_W'(pos) + LEN_W'(1);
                if (pos_inc >= len)
                begin
                    pos          = '0;
                    elap         = ELAP_IDLE;
                    prog         = 1'b0;
                    mask_next[i] = 1'b1;
                end
                else
                begin
                    pos = PW'(pos_inc);
                end
            end
            if (prog && elap < ELAP_MAX)
                elap = elap + ELAP_W'(1);
            pos_next[i]     = pos;
            elapsed_next[i] = elap;
            prog_next[i]    = prog;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            prev_reg      <= '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                cfg_reg[i]     <= '0;
                pos_reg[i]     <= '0;
                elapsed_reg[i] <= ELAP_IDLE;
                prog_reg[i]    <= 1'b0;
            end
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (advance)
            begin
                prev_reg <= now_sym;
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    pos_reg[i]     <= pos_next[i];
                    elapsed_reg[i] <= elapsed_next[i];
                    prog_reg[i]    <= prog_next[i];
                end
            end
            if (cfg_we)
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (cfg_index == IDX_W'(i))
                        cfg_reg[i] <= cfg_data;
                end
            end
        end
    end

    // payload: hold while stalled
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            dirs_reg <= s_tdata[DIR_W-1:0];
            btns_reg <= s_tdata[DIR_W +: BTN_W];
        end
        if (advance)
        begin
            mask_reg <= mask_next;
            sym_reg  <= now_sym;
        end
    end

endmodule

@@ design/tksd_checker.sv @@
module tksd_checker #(
    parameter int NUM_SLOTS = 8
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        cfg_we,
    input logic [tksd_pkg::IDX_W-1:0]  cfg_index,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [23:0]                 m_tdata
);
    import tksd_pkg::*;

    logic cfg_seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_seen_reg <= 1'b0;
        else if (cfg_we && int'(cfg_index) < NUM_SLOTS)
            cfg_seen_reg <= 1'b1;
    end

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed under stall");

    // folding leaves no plain direction next to one of its opposite axis
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[8 + SYM_D] && m_tdata[8 + SYM_F])
                  && !(m_tdata[8 + SYM_D] && m_tdata[8 + SYM_B])
                  && !(m_tdata[8 + SYM_U] && m_tdata[8 + SYM_F])
                  && !(m_tdata[8 + SYM_U] && m_tdata[8 + SYM_B]))
        else $error("unfolded diagonal in symbols");

    // no completion from a slot that does not exist
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:0] >> NUM_SLOTS) == 8'd0)
        else $error("completion beyond slot count");

    // slots reset empty, so nothing completes before a slot is written
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[7:0] != 8'd0 |-> cfg_seen_reg)
        else $error("completion with no command loaded");

endmodule

bind timed_key_sequence_detector_core tksd_checker #(.NUM_SLOTS(NUM_SLOTS)) u_tksd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);
